@@ sv/bpa_pkg.sv @@
// Shared types and constants for the bitmap page allocator.
// Used by the allocator, the bit search unit and the checker; depends on nothing.
`default_nettype none
package bpa_pkg;

	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;
	localparam int ADDR_W = 64;
	localparam int RANGE_W = 13;

	localparam logic [ADDR_W-1:0] WINDOW_RESET = 64'h9000_0000_0000_0000;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_REINIT = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_OOM    = 2'd1;
	localparam logic [1:0] ST_DOUBLE = 2'd2;
	localparam logic [1:0] ST_RANGE  = 2'd3;

	localparam logic [1:0] CFG_WINDOW    = 2'd0;
	localparam logic [1:0] CFG_RES_FIRST = 2'd1;
	localparam logic [1:0] CFG_RES_END   = 2'd2;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_FIND,
		S_FREE_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             done;
		logic [BIT_W-1:0] pos;
	} find_t;

endpackage
`default_nettype wire

@@ sv/bpa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the page bitmap words; no package dependency.
`default_nettype none
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/bpa_bitfind.sv @@
// Iterative search for the highest clear bit of a 64-bit map word.
// Halves the window once per cycle; uses find_t from bpa_pkg.
`default_nettype none
module bpa_bitfind (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [bpa_pkg::WORD_W-1:0] word,
	output bpa_pkg::find_t                 res
);

	logic                        busy_q;
	logic [2:0]                  step_q;
	logic [bpa_pkg::WORD_W-1:0]  win_q;
	logic [bpa_pkg::BIT_W-1:0]   base_q;
	logic [bpa_pkg::BIT_W-1:0]   half;
	logic [bpa_pkg::WORD_W-1:0]  half_mask;
	logic [bpa_pkg::WORD_W-1:0]  upper;
	logic                        hit;
	logic [bpa_pkg::BIT_W-1:0]   base_d;
	logic                        last;

	// Window holds free bits as ones; keep the upper half if it has any.
	always_comb begin
		half      = 6'd32 >> step_q;
		half_mask = (64'd1 << half) - 64'd1;
		upper     = (win_q >> half) & half_mask;
		hit       = |upper;
		base_d    = hit ? (base_q + half) : base_q;
		last      = (step_q == 3'd5);
		res.done  = busy_q && last;
		res.pos   = base_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 3'd0;
		end else if (busy_q) begin
			busy_q <= !last;
			step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			win_q  <= ~word;
			base_q <= '0;
		end else if (busy_q) begin
			win_q  <= hit ? upper : (win_q & half_mask);
			base_q <= base_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/bitmap_page_allocator.sv @@
// Channel   Dir  Payload                                   Handshake
// s_axis    in   tdata: page_address, tuser: kind          tvalid/tready
// m_axis    out  tdata: result_address, tuser: status      tvalid/tready
// cfg       in   cfg_index, cfg_data                       cfg_valid/cfg_ready
//
// Allocate reads one 64-bit map word per cycle from the top down until one has a
// clear bit, then the bit search unit finds its highest clear bit. Free reads the
// word, then checks and writes it back, then gives the result; an out-of-range address
// skips the read and check. Reinitialize rewrites the whole map. After reset the map
// is written one word per cycle, all WORDS words (PAGE_COUNT / 64 rounded up), while
// s_axis_tready stays low; configuration writes are taken at all times.
// A result waiting on m_axis does not hold off the next item, only its completion.
`default_nettype none
module bitmap_page_allocator #(
	parameter int PAGE_COUNT = 4096,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [63:0] page_address
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [63:0] m_axis_tdata,   // [63:0] result_address
	output logic      [1:0]  m_axis_tuser,   // [1:0] status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int WORDS = (PAGE_COUNT + 63) / 64;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BPW   = AW + bpa_pkg::BIT_W;
	localparam int CW    = (BPW + 1 > bpa_pkg::RANGE_W) ? BPW + 1 : bpa_pkg::RANGE_W;
	localparam logic [AW-1:0] LAST_W = AW'(WORDS - 1);
	localparam logic [CW-1:0] PC_C   = CW'(PAGE_COUNT);

	bpa_pkg::state_t state_q, state_d;

	logic [63:0]                 window_q;
	logic [bpa_pkg::RANGE_W-1:0] rfirst_q, rend_q;
	logic [bpa_pkg::RANGE_W-1:0] init_first_q, init_first_d;
	logic [bpa_pkg::RANGE_W-1:0] init_end_q, init_end_d;
	logic                        init_item_q, init_item_d;
	logic [AW-1:0]               sweep_q, sweep_d;
	logic [AW-1:0]               rd_w_q, rd_w_d;
	logic [bpa_pkg::BIT_W-1:0]   bit_q, bit_d;
	logic [63:0]                 word_q, word_d;
	logic [63:0]                 res_q, res_d;
	logic [1:0]                  st_q, st_d;
	logic                        out_load;
	logic                        m_tvalid_q;
	logic [63:0]                 m_tdata_q;
	logic [1:0]                  m_tuser_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;
	logic          find_start;
	bpa_pkg::find_t find_res;

	logic [63:0]   init_word;
	logic [CW-1:0] init_pos;
	logic [63:0]   free_idx;
	logic          free_range_err;
	logic [BPW-1:0] free_bits;

	bpa_ram #(
		.WIDTH(64),
		.DEPTH(WORDS),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bpa_bitfind u_find (
		.clk   (clk),
		.arst_n(arst_n),
		.start (find_start),
		.word  (word_d),
		.res   (find_res)
	);

	// Pages in the reserved range and bit slots past the last page read as used.
	always_comb begin
		init_word = '0;
		init_pos  = '0;
		for (int b = 0; b < 64; b++) begin
			init_pos     = CW'({sweep_q, 6'(b)});
			init_word[b] = (init_pos >= CW'(init_first_q) && init_pos < CW'(init_end_q))
				|| init_pos >= PC_C;
		end
	end

	always_comb begin
		free_idx       = (s_axis_tdata & ~window_q) >> PAGE_SHIFT;
		free_range_err = free_idx >= 64'(PAGE_COUNT);
		free_bits      = free_idx[BPW-1:0];
	end

	always_comb begin
		state_d      = state_q;
		sweep_d      = sweep_q;
		rd_w_d       = rd_w_q;
		bit_d        = bit_q;
		word_d       = word_q;
		res_d        = res_q;
		st_d         = st_q;
		init_first_d = init_first_q;
		init_end_d   = init_end_q;
		init_item_d  = init_item_q;
		ram_we       = 1'b0;
		ram_waddr    = sweep_q;
		ram_wdata    = init_word;
		ram_raddr    = rd_w_q;
		find_start   = 1'b0;
		out_load     = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			bpa_pkg::S_INIT: begin
				ram_we = 1'b1;
				if (sweep_q == LAST_W) begin
					res_d   = '0;
					st_d    = bpa_pkg::ST_OK;
					state_d = init_item_q ? bpa_pkg::S_DONE : bpa_pkg::S_IDLE;
				end else begin
					sweep_d = sweep_q + AW'(1);
				end
			end
			bpa_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (s_axis_tuser)
						bpa_pkg::KIND_ALLOC: begin
							ram_raddr = LAST_W;
							rd_w_d    = LAST_W;
							state_d   = bpa_pkg::S_SCAN;
						end
						bpa_pkg::KIND_FREE: begin
							if (free_range_err) begin
								res_d   = '0;
								st_d    = bpa_pkg::ST_RANGE;
								state_d = bpa_pkg::S_DONE;
							end else begin
								ram_raddr = free_bits[BPW-1:bpa_pkg::BIT_W];
								rd_w_d    = free_bits[BPW-1:bpa_pkg::BIT_W];
								bit_d     = free_bits[bpa_pkg::BIT_W-1:0];
								state_d   = bpa_pkg::S_FREE_CHK;
							end
						end
						bpa_pkg::KIND_REINIT: begin
							init_first_d = rfirst_q;
							init_end_d   = rend_q;
							init_item_d  = 1'b1;
							sweep_d      = '0;
							state_d      = bpa_pkg::S_INIT;
						end
						default: begin
							res_d   = '0;
							st_d    = bpa_pkg::ST_OK;
							state_d = bpa_pkg::S_DONE;
						end
					endcase
				end
			end
			bpa_pkg::S_SCAN: begin
				// ram_rdata holds the word at rd_w_q; fetch the next lower one meanwhile.
				if (!(&ram_rdata)) begin
					word_d     = ram_rdata;
					find_start = 1'b1;
					state_d    = bpa_pkg::S_FIND;
				end else if (rd_w_q == '0) begin
					res_d   = '0;
					st_d    = bpa_pkg::ST_OOM;
					state_d = bpa_pkg::S_DONE;
				end else begin
					rd_w_d    = rd_w_q - AW'(1);
					ram_raddr = rd_w_q - AW'(1);
				end
			end
			bpa_pkg::S_FIND: begin
				if (find_res.done) begin
					ram_we    = 1'b1;
					ram_waddr = rd_w_q;
					ram_wdata = word_q | (64'd1 << find_res.pos);
					res_d     = (64'({rd_w_q, find_res.pos}) << PAGE_SHIFT) | window_q;
					st_d      = bpa_pkg::ST_OK;
					state_d   = bpa_pkg::S_DONE;
				end
			end
			bpa_pkg::S_FREE_CHK: begin
				res_d = '0;
				if (!ram_rdata[bit_q]) begin
					st_d = bpa_pkg::ST_DOUBLE;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = rd_w_q;
					ram_wdata = ram_rdata & ~(64'd1 << bit_q);
					st_d      = bpa_pkg::ST_OK;
				end
				state_d = bpa_pkg::S_DONE;
			end
			bpa_pkg::S_DONE: begin
				if (!m_tvalid_q || m_axis_tready) begin
					out_load    = 1'b1;
					init_item_d = 1'b0;
					state_d     = bpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bpa_pkg::S_INIT;
			sweep_q      <= '0;
			init_first_q <= '0;
			init_end_q   <= '0;
			init_item_q  <= 1'b0;
			window_q     <= bpa_pkg::WINDOW_RESET;
			rfirst_q     <= '0;
			rend_q       <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			sweep_q      <= sweep_d;
			init_first_q <= init_first_d;
			init_end_q   <= init_end_d;
			init_item_q  <= init_item_d;
			if (cfg_valid) begin
				case (cfg_index)
					bpa_pkg::CFG_WINDOW:    window_q <= cfg_data;
					bpa_pkg::CFG_RES_FIRST: rfirst_q <= cfg_data[bpa_pkg::RANGE_W-1:0];
					bpa_pkg::CFG_RES_END:   rend_q   <= cfg_data[bpa_pkg::RANGE_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_w_q <= rd_w_d;
		bit_q  <= bit_d;
		word_q <= word_d;
		res_q  <= res_d;
		st_q   <= st_d;
		if (out_load) begin
			m_tdata_q <= res_q;
			m_tuser_q <= st_q;
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule
`default_nettype wire

@@ sv/bpa_checker.sv @@
// Port-level checks for bitmap_page_allocator, bound to the top level.
// Uses status codes from bpa_pkg.
`default_nettype none
module bpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	// A stalled result keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// Any failure status carries a zero address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != bpa_pkg::ST_OK |-> m_axis_tdata == 64'd0)
		else $error("failed item returned a nonzero address");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item taken while another is in work");

	// Configuration writes are never held off.
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
`default_nettype wire
